@@ hw/rtl/psne_pkg.sv @@
package psne_pkg;

    localparam int MAX_SAMPLES  = 1024;
    localparam int MAX_FEATURES = 16;
    localparam int SAMP_BITS    = 10;
    localparam int FEAT_BITS    = 4;
    localparam int CNT_BITS     = 11;
    localparam int NF_BITS      = 5;
    localparam int VALUE_BITS   = 32;
    localparam int RANK_BITS    = 10;
    localparam int CLASS_BITS   = 8;
    localparam int ENTRY_BITS   = VALUE_BITS + RANK_BITS;
    localparam int STORE_DEPTH  = MAX_FEATURES * MAX_SAMPLES;
    localparam int STORE_ABITS  = FEAT_BITS + SAMP_BITS;

    localparam logic [1:0] ACT_WRITE      = 2'd0;
    localparam logic [1:0] ACT_SPLIT_THR  = 2'd1;
    localparam logic [1:0] ACT_SPLIT_RANK = 2'd2;
    localparam logic [1:0] ACT_READ       = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic CFG_NUM_FEATURES = 1'b0;
    localparam logic CFG_NUM_SAMPLES  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD,
        S_MARK_RD,
        S_MARK_WR,
        S_CHECK,
        S_PA_RD,
        S_PA_WR,
        S_PB_RD,
        S_PB_WR,
        S_CL,
        S_CM_RD,
        S_CM_WR,
        S_PS_RD,
        S_PS_WR,
        S_RM_RD,
        S_RM_MAP,
        S_RM_WR
    } t_state;

    typedef struct packed {
        logic                         valid;
        logic [1:0]                   status;
        logic [CNT_BITS-1:0]          left_count;
        logic [CNT_BITS-1:0]          right_count;
        logic signed [VALUE_BITS-1:0] value_out;
        logic [RANK_BITS-1:0]         rank_out;
        logic [CLASS_BITS-1:0]        class_out;
    } t_result;

endpackage

@@ hw/rtl/psne_ram.sv @@
module psne_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ hw/rtl/presorted_node_split_engine.sv @@
// Presorted node split engine. An item is taken when start is high and busy is
// low; its single result word appears on the o_ result ports for one cycle with
// o_done, and the receiver cannot stall it. A write item answers in the cycle
// after it is taken; a read item passes S_RD and then the result register. A
// split runs one memory access per step on a single read and write port of each
// store; the clearing and the prefix sweep of the 1024-entry rank map cover all
// its entries and are done twice per feature. A split that finds one side empty
// answers from S_CHECK once the marking pass is done. Configuration is taken
// only while busy and start are both low.
module presorted_node_split_engine (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             i_action,
    input  logic [psne_pkg::FEAT_BITS-1:0]         i_feature_index,
    input  logic [psne_pkg::SAMP_BITS-1:0]         i_sample_index,
    input  logic signed [psne_pkg::VALUE_BITS-1:0] i_value_in,
    input  logic [psne_pkg::RANK_BITS-1:0]         i_rank_in,
    input  logic [psne_pkg::CLASS_BITS-1:0]        i_class_in,
    input  logic signed [psne_pkg::VALUE_BITS-1:0] i_threshold,
    input  logic [psne_pkg::SAMP_BITS-1:0]         i_segment_start,
    input  logic [psne_pkg::CNT_BITS-1:0]          i_segment_length,
    input  logic [psne_pkg::CNT_BITS-1:0]          i_split_rank,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic                                   i_cfg_index,
    input  logic [psne_pkg::CNT_BITS-1:0]          i_cfg_data,
    output logic                                   o_done,
    output logic [1:0]                             o_status,
    output logic [psne_pkg::CNT_BITS-1:0]          o_left_count,
    output logic [psne_pkg::CNT_BITS-1:0]          o_right_count,
    output logic signed [psne_pkg::VALUE_BITS-1:0] o_value_out,
    output logic [psne_pkg::RANK_BITS-1:0]         o_rank_out,
    output logic [psne_pkg::CLASS_BITS-1:0]        o_class_out
);

    import psne_pkg::*;

    t_state r_state, n_state;
    t_result fin, r_res;

    logic [NF_BITS-1:0]           r_num_features;
    logic [CNT_BITS-1:0]          r_num_samples;
    logic [1:0]                   r_action;
    logic [FEAT_BITS-1:0]         r_feat;
    logic signed [VALUE_BITS-1:0] r_threshold;
    logic [SAMP_BITS-1:0]         r_start;
    logic [CNT_BITS-1:0]          r_len;
    logic [CNT_BITS-1:0]          r_split_rank;
    logic [CNT_BITS-1:0]          r_k;
    logic [CNT_BITS-1:0]          r_wl;
    logic [CNT_BITS-1:0]          r_wr;
    logic [CNT_BITS-1:0]          r_nright;
    logic [CNT_BITS-1:0]          r_nleft;
    logic [CNT_BITS-1:0]          r_sum;
    logic [FEAT_BITS-1:0]         r_f;
    logic                         r_tgt_cls;
    logic                         r_side;

    // Memory ports.
    logic                   st_we;
    logic [STORE_ABITS-1:0] st_waddr, st_raddr;
    logic [ENTRY_BITS-1:0]  st_wdata, st_rdata;
    logic                   cls_we;
    logic [SAMP_BITS-1:0]   cls_waddr, cls_raddr;
    logic [CLASS_BITS-1:0]  cls_wdata, cls_rdata;
    logic                   mk_we;
    logic [SAMP_BITS-1:0]   mk_waddr, mk_raddr;
    logic [0:0]             mk_wdata, mk_rdata;
    logic                   rb_we;
    logic [SAMP_BITS-1:0]   rb_waddr, rb_raddr;
    logic [ENTRY_BITS-1:0]  rb_wdata, rb_rdata;
    logic                   mp_we;
    logic [SAMP_BITS-1:0]   mp_waddr, mp_raddr;
    logic [CNT_BITS-1:0]    mp_wdata, mp_rdata;

    logic [NF_BITS-1:0]    nf_eff;
    logic [CNT_BITS-1:0]   ns_eff;
    logic                  accept;
    logic                  in_bad_addr, in_bad_split;
    logic [CNT_BITS-1:0]   seg_k, seg_wl, seg_pb, seg_cm, n_cmp, sum_nx;
    logic                  last_len, last_wr, last_cmp, last_map, last_f;
    logic                  right, empty;
    logic [ENTRY_BITS-1:0] vec_data;
    logic [RANK_BITS-1:0]  rank_new;

    psne_ram #(.DEPTH(STORE_DEPTH), .WIDTH(ENTRY_BITS)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_rdata)
    );
    psne_ram #(.DEPTH(MAX_SAMPLES), .WIDTH(CLASS_BITS)) u_class (
        .i_clk(i_clk), .i_we(cls_we), .i_waddr(cls_waddr), .i_wdata(cls_wdata),
        .i_raddr(cls_raddr), .o_rdata(cls_rdata)
    );
    psne_ram #(.DEPTH(MAX_SAMPLES), .WIDTH(1)) u_marks (
        .i_clk(i_clk), .i_we(mk_we), .i_waddr(mk_waddr), .i_wdata(mk_wdata),
        .i_raddr(mk_raddr), .o_rdata(mk_rdata)
    );
    psne_ram #(.DEPTH(MAX_SAMPLES), .WIDTH(ENTRY_BITS)) u_rbuf (
        .i_clk(i_clk), .i_we(rb_we), .i_waddr(rb_waddr), .i_wdata(rb_wdata),
        .i_raddr(rb_raddr), .o_rdata(rb_rdata)
    );
    psne_ram #(.DEPTH(MAX_SAMPLES), .WIDTH(CNT_BITS)) u_map (
        .i_clk(i_clk), .i_we(mp_we), .i_waddr(mp_waddr), .i_wdata(mp_wdata),
        .i_raddr(mp_raddr), .o_rdata(mp_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    // A register write never lands on the edge that takes an item.
    assign o_cfg_ready = !busy && !start;
    assign accept      = start && !busy;

    always_comb begin
        if (r_num_features == '0) begin
            nf_eff = NF_BITS'(1);
        end else if (r_num_features > NF_BITS'(MAX_FEATURES)) begin
            nf_eff = NF_BITS'(MAX_FEATURES);
        end else begin
            nf_eff = r_num_features;
        end
        if (r_num_samples == '0) begin
            ns_eff = CNT_BITS'(1);
        end else if (r_num_samples > CNT_BITS'(MAX_SAMPLES)) begin
            ns_eff = CNT_BITS'(MAX_SAMPLES);
        end else begin
            ns_eff = r_num_samples;
        end
    end

    assign in_bad_addr  = ({1'b0, i_feature_index} >= nf_eff) ||
                          ({1'b0, i_sample_index} >= ns_eff);
    assign in_bad_split = ({1'b0, i_feature_index} >= nf_eff) ||
                          (({2'b0, i_segment_start} + {1'b0, i_segment_length}) >
                           {1'b0, ns_eff});

    assign seg_k  = {1'b0, r_start} + r_k;
    assign seg_wl = {1'b0, r_start} + r_wl;
    assign seg_pb = {1'b0, r_start} + r_nleft + r_k;
    assign seg_cm = {1'b0, r_start} + (r_side ? r_nleft : '0) + r_k;
    assign n_cmp  = r_side ? r_nright : r_nleft;
    assign sum_nx = r_sum + mp_rdata;

    assign last_len = (r_k == r_len - 1'b1);
    assign last_wr  = (r_k == r_wr - 1'b1);
    assign last_cmp = (r_k == n_cmp - 1'b1);
    assign last_map = (r_k[SAMP_BITS-1:0] == '1);
    assign last_f   = ({1'b0, r_f} == nf_eff - 1'b1);
    assign empty    = (r_nright == '0) || (r_nright == r_len);

    assign right = (r_action == ACT_SPLIT_THR) ?
                   ($signed(st_rdata[ENTRY_BITS-1:RANK_BITS]) >= r_threshold) :
                   ({1'b0, st_rdata[RANK_BITS-1:0]} >= r_split_rank);
    assign vec_data = r_tgt_cls ? {{(ENTRY_BITS-CLASS_BITS){1'b0}}, cls_rdata} : st_rdata;
    assign rank_new = RANK_BITS'(mp_rdata - 1'b1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_WRITE: n_state = S_IDLE;
                        ACT_READ:  n_state = in_bad_addr ? S_IDLE : S_RD;
                        default: begin
                            if (!in_bad_split && i_segment_length != '0) begin
                                n_state = S_MARK_RD;
                            end
                        end
                    endcase
                end
            end
            S_RD:      n_state = S_IDLE;
            S_MARK_RD: n_state = S_MARK_WR;
            S_MARK_WR: n_state = last_len ? S_CHECK : S_MARK_RD;
            S_CHECK:   n_state = empty ? S_IDLE : S_PA_RD;
            S_PA_RD:   n_state = S_PA_WR;
            S_PA_WR:   n_state = last_len ? S_PB_RD : S_PA_RD;
            S_PB_RD:   n_state = S_PB_WR;
            S_PB_WR: begin
                if (last_wr) begin
                    n_state = r_tgt_cls ? S_PA_RD : S_CL;
                end else begin
                    n_state = S_PB_RD;
                end
            end
            S_CL:      n_state = last_map ? S_CM_RD : S_CL;
            S_CM_RD:   n_state = S_CM_WR;
            S_CM_WR:   n_state = last_cmp ? S_PS_RD : S_CM_RD;
            S_PS_RD:   n_state = S_PS_WR;
            S_PS_WR:   n_state = last_map ? S_RM_RD : S_PS_RD;
            S_RM_RD:   n_state = S_RM_MAP;
            S_RM_MAP:  n_state = S_RM_WR;
            S_RM_WR: begin
                if (!last_cmp) begin
                    n_state = S_RM_RD;
                end else if (!r_side) begin
                    n_state = S_CL;
                end else begin
                    n_state = last_f ? S_IDLE : S_PA_RD;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Memory controls and the result word.
    always_comb begin
        st_we = 1'b0;  st_waddr = '0;  st_wdata = '0;  st_raddr = '0;
        cls_we = 1'b0; cls_waddr = '0; cls_wdata = '0; cls_raddr = '0;
        mk_we = 1'b0;  mk_waddr = '0;  mk_wdata = '0;  mk_raddr = '0;
        rb_we = 1'b0;  rb_waddr = '0;  rb_wdata = '0;  rb_raddr = '0;
        mp_we = 1'b0;  mp_waddr = '0;  mp_wdata = '0;  mp_raddr = '0;
        fin = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_WRITE: begin
                            fin.valid = 1'b1;
                            if (in_bad_addr) begin
                                fin.status = ST_BAD;
                            end else begin
                                fin.status = ST_DONE;
                                st_we     = 1'b1;
                                st_waddr  = {i_feature_index, i_sample_index};
                                st_wdata  = {i_value_in, i_rank_in};
                                cls_we    = 1'b1;
                                cls_waddr = i_sample_index;
                                cls_wdata = i_class_in;
                            end
                        end
                        ACT_READ: begin
                            st_raddr  = {i_feature_index, i_sample_index};
                            cls_raddr = i_sample_index;
                            if (in_bad_addr) begin
                                fin.valid  = 1'b1;
                                fin.status = ST_BAD;
                            end
                        end
                        default: begin
                            if (in_bad_split) begin
                                fin.valid  = 1'b1;
                                fin.status = ST_BAD;
                            end else if (i_segment_length == '0) begin
                                fin.valid  = 1'b1;
                                fin.status = ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                fin.valid     = 1'b1;
                fin.status    = ST_DONE;
                fin.value_out = st_rdata[ENTRY_BITS-1:RANK_BITS];
                fin.rank_out  = st_rdata[RANK_BITS-1:0];
                fin.class_out = cls_rdata;
            end
            S_MARK_RD: st_raddr = {r_feat, seg_k[SAMP_BITS-1:0]};
            S_MARK_WR: begin
                mk_we    = 1'b1;
                mk_waddr = r_k[SAMP_BITS-1:0];
                mk_wdata = right;
            end
            S_CHECK: begin
                if (empty) begin
                    fin.valid  = 1'b1;
                    fin.status = ST_EMPTY;
                end
            end
            S_PA_RD: begin
                st_raddr  = {r_f, seg_k[SAMP_BITS-1:0]};
                cls_raddr = seg_k[SAMP_BITS-1:0];
                mk_raddr  = r_k[SAMP_BITS-1:0];
            end
            S_PA_WR: begin
                if (mk_rdata[0]) begin
                    rb_we    = 1'b1;
                    rb_waddr = r_wr[SAMP_BITS-1:0];
                    rb_wdata = vec_data;
                end else if (r_tgt_cls) begin
                    cls_we    = 1'b1;
                    cls_waddr = seg_wl[SAMP_BITS-1:0];
                    cls_wdata = vec_data[CLASS_BITS-1:0];
                end else begin
                    st_we    = 1'b1;
                    st_waddr = {r_f, seg_wl[SAMP_BITS-1:0]};
                    st_wdata = vec_data;
                end
            end
            S_PB_RD: rb_raddr = r_k[SAMP_BITS-1:0];
            S_PB_WR: begin
                if (r_tgt_cls) begin
                    cls_we    = 1'b1;
                    cls_waddr = seg_pb[SAMP_BITS-1:0];
                    cls_wdata = rb_rdata[CLASS_BITS-1:0];
                end else begin
                    st_we    = 1'b1;
                    st_waddr = {r_f, seg_pb[SAMP_BITS-1:0]};
                    st_wdata = rb_rdata;
                end
            end
            S_CL: begin
                mp_we    = 1'b1;
                mp_waddr = r_k[SAMP_BITS-1:0];
            end
            S_CM_RD: st_raddr = {r_f, seg_cm[SAMP_BITS-1:0]};
            S_CM_WR: begin
                mp_we    = 1'b1;
                mp_waddr = st_rdata[RANK_BITS-1:0];
                mp_wdata = CNT_BITS'(1);
            end
            S_PS_RD: mp_raddr = r_k[SAMP_BITS-1:0];
            S_PS_WR: begin
                mp_we    = 1'b1;
                mp_waddr = r_k[SAMP_BITS-1:0];
                mp_wdata = sum_nx;
            end
            S_RM_RD: st_raddr = {r_f, seg_cm[SAMP_BITS-1:0]};
            S_RM_MAP: begin
                // Re-read the same entry so its value is still there next cycle.
                st_raddr = {r_f, seg_cm[SAMP_BITS-1:0]};
                mp_raddr = st_rdata[RANK_BITS-1:0];
            end
            S_RM_WR: begin
                st_we    = 1'b1;
                st_waddr = {r_f, seg_cm[SAMP_BITS-1:0]};
                st_wdata = {st_rdata[ENTRY_BITS-1:RANK_BITS], rank_new};
                if (last_cmp && r_side && last_f) begin
                    fin.valid       = 1'b1;
                    fin.status      = ST_DONE;
                    fin.left_count  = r_nleft;
                    fin.right_count = r_nright;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_res          <= '0;
            r_num_features <= NF_BITS'(MAX_FEATURES);
            r_num_samples  <= CNT_BITS'(MAX_SAMPLES);
        end else begin
            r_state <= n_state;
            r_res   <= fin;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_NUM_FEATURES: r_num_features <= i_cfg_data[NF_BITS-1:0];
                    CFG_NUM_SAMPLES:  r_num_samples  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_action     <= i_action;
                    r_feat       <= i_feature_index;
                    r_threshold  <= i_threshold;
                    r_start      <= i_segment_start;
                    r_len        <= i_segment_length;
                    r_split_rank <= i_split_rank;
                    r_k          <= '0;
                    r_nright     <= '0;
                end
            end
            S_MARK_WR: begin
                r_k      <= r_k + 1'b1;
                r_nright <= r_nright + CNT_BITS'(right);
            end
            S_CHECK: begin
                r_nleft   <= r_len - r_nright;
                r_tgt_cls <= 1'b1;
                r_f       <= '0;
                r_k       <= '0;
                r_wl      <= '0;
                r_wr      <= '0;
            end
            S_PA_WR: begin
                r_k <= last_len ? '0 : r_k + 1'b1;
                if (mk_rdata[0]) begin
                    r_wr <= r_wr + 1'b1;
                end else begin
                    r_wl <= r_wl + 1'b1;
                end
            end
            S_PB_WR: begin
                if (last_wr) begin
                    r_k <= '0;
                    if (r_tgt_cls) begin
                        r_tgt_cls <= 1'b0;
                        r_wl      <= '0;
                        r_wr      <= '0;
                    end else begin
                        r_side <= 1'b0;
                    end
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            S_CL: r_k <= last_map ? '0 : r_k + 1'b1;
            S_CM_WR: begin
                r_k   <= last_cmp ? '0 : r_k + 1'b1;
                r_sum <= '0;
            end
            S_PS_WR: begin
                r_sum <= sum_nx;
                r_k   <= last_map ? '0 : r_k + 1'b1;
            end
            S_RM_WR: begin
                if (last_cmp) begin
                    r_k <= '0;
                    if (!r_side) begin
                        r_side <= 1'b1;
                    end else begin
                        r_f  <= r_f + 1'b1;
                        r_wl <= '0;
                        r_wr <= '0;
                    end
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_done        = r_res.valid;
    assign o_status      = r_res.status;
    assign o_left_count  = r_res.left_count;
    assign o_right_count = r_res.right_count;
    assign o_value_out   = r_res.value_out;
    assign o_rank_out    = r_res.rank_out;
    assign o_class_out   = r_res.class_out;

    a_counts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_left_count != '0) |->
        ({1'b0, o_left_count} + {1'b0, o_right_count} == {1'b0, r_len}))
        else $error("split counts do not add up to the segment length");

    a_partition_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PA_RD) |-> (r_wl + r_wr == r_k))
        else $error("partition write pointers lost track of the read pointer");

    a_right_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PB_RD || r_state == S_PB_WR) |-> (r_wr == r_nright))
        else $error("right buffer fill differs from the marked right count");

    a_map_sweep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CL || r_state == S_PS_WR) |-> (!st_we && !cls_we))
        else $error("store written during a rank map sweep");

endmodule

@@ bench/tb_presorted_node_split_engine.sv @@
`timescale 1ns / 1ps

module tb_presorted_node_split_engine;
    import psne_pkg::*;

    localparam int IDLE_LIMIT = 1000000;

    typedef struct {
        logic [1:0]                   action;
        logic [FEAT_BITS-1:0]         feat;
        logic [SAMP_BITS-1:0]         samp;
        logic signed [VALUE_BITS-1:0] value;
        logic [RANK_BITS-1:0]         rank;
        logic [CLASS_BITS-1:0]        cls;
        logic signed [VALUE_BITS-1:0] thr;
        logic [SAMP_BITS-1:0]         seg_start;
        logic [CNT_BITS-1:0]          seg_len;
        logic [CNT_BITS-1:0]          split_rank;
    } item_t;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    item_t                        drv;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic                         i_cfg_index = 1'b0;
    logic [CNT_BITS-1:0]          i_cfg_data = '0;
    logic                         o_done;
    logic [1:0]                   o_status;
    logic [CNT_BITS-1:0]          o_left_count;
    logic [CNT_BITS-1:0]          o_right_count;
    logic signed [VALUE_BITS-1:0] o_value_out;
    logic [RANK_BITS-1:0]         o_rank_out;
    logic [CLASS_BITS-1:0]        o_class_out;

    // Shadow copy of the stores and the two registers.
    logic signed [VALUE_BITS-1:0] value_mem [MAX_FEATURES][MAX_SAMPLES];
    logic [RANK_BITS-1:0]         rank_mem  [MAX_FEATURES][MAX_SAMPLES];
    logic [CLASS_BITS-1:0]        class_mem [MAX_SAMPLES];
    logic [CNT_BITS-1:0]          reg_features = 11'd16;
    logic [CNT_BITS-1:0]          reg_samples  = 11'd1024;

    t_result pending_results[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    int      burst_left  = 0;

    always #1 i_clk = ~i_clk;

    initial begin
        drv = '{default: '0};
    end

    presorted_node_split_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(drv.action), .i_feature_index(drv.feat), .i_sample_index(drv.samp),
        .i_value_in(drv.value), .i_rank_in(drv.rank), .i_class_in(drv.cls),
        .i_threshold(drv.thr), .i_segment_start(drv.seg_start),
        .i_segment_length(drv.seg_len), .i_split_rank(drv.split_rank),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_done(o_done), .o_status(o_status),
        .o_left_count(o_left_count), .o_right_count(o_right_count),
        .o_value_out(o_value_out), .o_rank_out(o_rank_out), .o_class_out(o_class_out)
    );

    function automatic int eff_features();
        int n;
        n = reg_features[4:0];
        if (n < 1) n = 1;
        if (n > MAX_FEATURES) n = MAX_FEATURES;
        return n;
    endfunction

    function automatic int eff_samples();
        int n;
        n = reg_samples;
        if (n < 1) n = 1;
        if (n > MAX_SAMPLES) n = MAX_SAMPLES;
        return n;
    endfunction

    // Each rank becomes the number of distinct smaller ranks on its side.
    function automatic void compact_side(int f, int base, int n);
        bit seen [MAX_SAMPLES];
        int below [MAX_SAMPLES];
        int sum;
        sum = 0;
        for (int k = 0; k < MAX_SAMPLES; k++) seen[k] = 0;
        for (int k = 0; k < n; k++) seen[rank_mem[f][base+k]] = 1;
        for (int v = 0; v < MAX_SAMPLES; v++) begin
            below[v] = sum;
            if (seen[v]) sum++;
        end
        for (int k = 0; k < n; k++)
            rank_mem[f][base+k] = RANK_BITS'(below[rank_mem[f][base+k]]);
    endfunction

    function automatic t_result split_node(item_t it);
        t_result r;
        bit right_side [MAX_SAMPLES];
        logic signed [VALUE_BITS-1:0] vtmp [MAX_SAMPLES];
        logic [RANK_BITS-1:0] rtmp [MAX_SAMPLES];
        logic [CLASS_BITS-1:0] ctmp [MAX_SAMPLES];
        int nf, len, base, nright, nleft, wl, wr;
        r = '0;
        nf = eff_features();
        len = it.seg_len;
        base = it.seg_start;
        if (it.feat >= nf || base + len > eff_samples()) begin
            r.status = ST_BAD;
            return r;
        end
        nright = 0;
        for (int k = 0; k < len; k++) begin
            if (it.action == ACT_SPLIT_THR)
                right_side[k] = value_mem[it.feat][base+k] >= it.thr;
            else
                right_side[k] = {1'b0, rank_mem[it.feat][base+k]} >= it.split_rank;
            if (right_side[k]) nright++;
        end
        nleft = len - nright;
        if (nleft == 0 || nright == 0) begin
            r.status = ST_EMPTY;
            return r;
        end
        r.status = ST_DONE;
        r.left_count = CNT_BITS'(nleft);
        r.right_count = CNT_BITS'(nright);
        wl = 0;
        wr = nleft;
        for (int k = 0; k < len; k++) begin
            if (right_side[k]) ctmp[wr++] = class_mem[base+k];
            else ctmp[wl++] = class_mem[base+k];
        end
        for (int k = 0; k < len; k++) class_mem[base+k] = ctmp[k];
        for (int f = 0; f < nf; f++) begin
            wl = 0;
            wr = nleft;
            for (int k = 0; k < len; k++) begin
                if (right_side[k]) begin
                    vtmp[wr] = value_mem[f][base+k];
                    rtmp[wr++] = rank_mem[f][base+k];
                end else begin
                    vtmp[wl] = value_mem[f][base+k];
                    rtmp[wl++] = rank_mem[f][base+k];
                end
            end
            for (int k = 0; k < len; k++) begin
                value_mem[f][base+k] = vtmp[k];
                rank_mem[f][base+k] = rtmp[k];
            end
            compact_side(f, base, nleft);
            compact_side(f, base + nleft, nright);
        end
        return r;
    endfunction

    function automatic t_result apply_item(item_t it);
        t_result r;
        r = '0;
        if (it.action == ACT_WRITE || it.action == ACT_READ) begin
            if (it.feat >= eff_features() || it.samp >= eff_samples()) begin
                r.status = ST_BAD;
            end else if (it.action == ACT_WRITE) begin
                value_mem[it.feat][it.samp] = it.value;
                rank_mem[it.feat][it.samp] = it.rank;
                class_mem[it.samp] = it.cls;
            end else begin
                r.value_out = value_mem[it.feat][it.samp];
                r.rank_out = rank_mem[it.feat][it.samp];
                r.class_out = class_mem[it.samp];
            end
        end else begin
            r = split_node(it);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // The sender works in bursts; a gap follows each burst.
    task automatic send_item(item_t it);
        @(negedge i_clk);
        drv = it;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_item(it));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) :
                         $urandom_range(0, 6);
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_register(logic index, logic [CNT_BITS-1:0] data);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_NUM_FEATURES) reg_features = data;
        else reg_samples = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic item_t make_item(logic [1:0] action, int feat, int samp);
        item_t it;
        it.action = action;
        it.feat = FEAT_BITS'(feat);
        it.samp = SAMP_BITS'(samp);
        it.value = ($urandom_range(0, 3) == 0) ? $signed($urandom_range(0, 40) - 20) :
                   $urandom;
        it.rank = ($urandom_range(0, 2) == 0) ? RANK_BITS'($urandom_range(0, 1023)) :
                  RANK_BITS'($urandom_range(0, eff_samples() - 1));
        it.cls = CLASS_BITS'($urandom);
        it.thr = $urandom;
        it.seg_start = SAMP_BITS'($urandom);
        it.seg_len = CNT_BITS'($urandom_range(0, 1024));
        it.split_rank = CNT_BITS'($urandom_range(0, 1024));
        return it;
    endfunction

    task automatic fill_store();
        for (int s = 0; s < eff_samples(); s++)
            for (int f = 0; f < eff_features(); f++)
                send_item(make_item(ACT_WRITE, f, s));
    endtask

    // Mostly well-formed splits whose threshold or rank comes from the segment.
    function automatic item_t random_split();
        item_t it;
        int ns, pick;
        ns = eff_samples();
        it = make_item($urandom_range(0, 1) ? ACT_SPLIT_THR : ACT_SPLIT_RANK,
                       $urandom_range(0, eff_features() - 1), 0);
        it.seg_start = SAMP_BITS'($urandom_range(0, ns - 1));
        it.seg_len = CNT_BITS'($urandom_range(1, ns - it.seg_start));
        pick = it.seg_start + $urandom_range(0, it.seg_len - 1);
        if ($urandom_range(0, 4) != 0) begin
            it.thr = value_mem[it.feat][pick] + $urandom_range(0, 1);
            it.split_rank = CNT_BITS'(rank_mem[it.feat][pick] + $urandom_range(0, 1));
        end
        return it;
    endfunction

    function automatic item_t random_item(bit splits_only);
        int sel, nf, ns;
        nf = eff_features();
        ns = eff_samples();
        sel = splits_only ? 60 : $urandom_range(0, 99);
        if (sel < 30)
            return make_item(ACT_WRITE, $urandom_range(0, nf - 1), $urandom_range(0, ns - 1));
        if (sel < 55)
            return make_item(ACT_READ, $urandom_range(0, nf - 1), $urandom_range(0, ns - 1));
        if (sel < 92)
            return random_split();
        // Arguments possibly out of range, any field bit pattern.
        return make_item(2'($urandom_range(0, 3)), $urandom_range(0, 15),
                         $urandom_range(0, 1023));
    endfunction

    task automatic run_random(int count, bit splits_only);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) wait_drained();
            send_item(random_item(splits_only));
        end
    endtask

    task automatic test_default_extremes();
        item_t it;
        it = make_item(ACT_WRITE, 15, 1023);
        it.value = 32'sh7FFF_FFFF;
        it.rank = 10'd1023;
        it.cls = 8'hFF;
        send_item(it);
        it = make_item(ACT_WRITE, 0, 0);
        it.value = 32'sh8000_0000;
        it.rank = '0;
        it.cls = '0;
        send_item(it);
        send_item(make_item(ACT_READ, 15, 1023));
        send_item(make_item(ACT_READ, 0, 0));
        it = make_item(ACT_SPLIT_THR, 15, 0);
        it.seg_start = 10'd1023;
        it.seg_len = 11'd1;
        send_item(it);
        it.action = ACT_SPLIT_RANK;
        it.seg_len = '0;
        send_item(it);
        it.seg_len = 11'd2;
        send_item(it);
        it.seg_len = 11'd1024;
        send_item(it);
    endtask

    task automatic test_register_limits();
        item_t it;
        write_register(CFG_NUM_FEATURES, '0);
        write_register(CFG_NUM_SAMPLES, '0);
        send_item(make_item(ACT_WRITE, 1, 0));
        send_item(make_item(ACT_WRITE, 0, 1));
        send_item(make_item(ACT_READ, 0, 1));
        send_item(make_item(ACT_WRITE, 0, 0));
        send_item(make_item(ACT_READ, 0, 0));
        it = make_item(ACT_SPLIT_THR, 0, 0);
        it.seg_start = '0;
        it.seg_len = 11'd1;
        send_item(it);
        it.seg_len = 11'd2;
        send_item(it);
        write_register(CFG_NUM_FEATURES, 11'h7FF);
        write_register(CFG_NUM_SAMPLES, 11'h7FF);
        send_item(make_item(ACT_READ, 15, 1023));
        write_register(CFG_NUM_FEATURES, 11'd17);
        send_item(make_item(ACT_READ, 15, 1023));
    endtask

    task automatic test_all_features();
        write_register(CFG_NUM_FEATURES, 11'd16);
        write_register(CFG_NUM_SAMPLES, 11'd2);
        fill_store();
        run_random(2, 1'b1);
    endtask

    task automatic test_random_mix();
        write_register(CFG_NUM_FEATURES, 11'd2);
        write_register(CFG_NUM_SAMPLES, 11'd12);
        fill_store();
        run_random(30, 1'b0);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (o_done) begin
            if (pending_results.size() == 0) begin
                $display("unexpected result word at %0t", $realtime);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_left_count !== want.left_count)
                    report_mismatch("left_count", o_left_count, want.left_count);
                if (o_right_count !== want.right_count)
                    report_mismatch("right_count", o_right_count, want.right_count);
                if (o_value_out !== want.value_out)
                    report_mismatch("value_out", o_value_out, want.value_out);
                if (o_rank_out !== want.rank_out)
                    report_mismatch("rank_out", o_rank_out, want.rank_out);
                if (o_class_out !== want.class_out)
                    report_mismatch("class_out", o_class_out, want.class_out);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_default_extremes();
        test_register_limits();
        test_all_features();
        test_random_mix();
        wait_drained();
        repeat (50) @(negedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
